// File: rtl/sao_pkg.sv
package sao_pkg;

  // Fixed widths of the stream fields.
  localparam int WORD_W          = 32;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 7;
  localparam int STACK_DEPTH_DEF = 64;

  // Operation codes carried on the input side.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_SWAP = 3'd1,
    FN_ADD  = 3'd2,
    FN_SUB  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  // Status codes carried on the result side.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // What one stack cell does at the next clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD     = 2'd0,
    CMD_SHIFT_DN = 2'd1,
    CMD_SHIFT_UP = 2'd2,
    CMD_LOAD     = 2'd3
  } cell_cmd_t;

  // Control handed to each cell by the sequencer.
  typedef struct packed {
    cell_cmd_t           cmd;
    logic [WORD_W-1:0]   load_word;
  } cell_ctl_t;

endpackage

// File: rtl/sao_cell.sv
module sao_cell
  import sao_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] above_word,
  input  logic [WORD_W-1:0] below_word,
  output logic [WORD_W-1:0] word_q
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // A push moves words away from the top, a pop pulls them back toward it.
  always_comb begin
    case (ctl.cmd)
      CMD_HOLD:     word_nxt = word_r;
      CMD_SHIFT_DN: word_nxt = above_word;
      CMD_SHIFT_UP: word_nxt = below_word;
      CMD_LOAD:     word_nxt = ctl.load_word;
      default:      word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// File: rtl/sao_div.sv
module sao_div
  import sao_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quot
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic              neg_r,   neg_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [WORD_W-1:0] rem_r,   rem_nxt;
  logic [WORD_W-1:0] quo_r,   quo_nxt;
  logic [WORD_W-1:0] den_r,   den_nxt;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;
  logic [WORD_W-1:0] num_mag;
  logic [WORD_W-1:0] den_mag;

  // Magnitudes of the operands; the most negative word maps onto itself.
  assign num_mag = num[WORD_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[WORD_W-1] ? (~den + 1'b1) : den;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[WORD_W-1] ^ den[WORD_W-1];
      cnt_nxt  = CNT_W'(WORD_W - 1);
      rem_nxt  = '0;
      quo_nxt  = num_mag;
      den_nxt  = den_mag;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  // Apply the quotient sign; truncation toward zero falls out of the magnitudes.
  assign done = done_r;
  assign quot = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// File: rtl/stack_alu_ops.sv
// Stack ALU: an operand stack of signed 32-bit words driven by one operation
// per input word.
// Input channel: in_tuser carries the operation (push, swap, add, sub, div),
// in_tdata the word to push. Result channel: out_tuser carries the status
// (ok, stack too short, division by zero, stack full), out_tdata the word on
// top of the stack afterwards and the stack depth.
// Every input word yields exactly one result word.
// Push, swap, add, sub and any rejected operation need no extra wait: the
// result is registered at the edge that takes the input, and the next input
// can follow in the next cycle unless the receiver stalls.
// A division loads the divider at the edge that takes the input, runs the
// one-bit-per-cycle restoring divider, and then writes the quotient back into
// the stack before the next input is taken.
// The stack is a row of cells, top word in the first cell; a push shifts every
// cell by one place, a pop loads the first cell and shifts the rest, all in the same cycle.
// Reset empties the stack (depth zero) and drops any pending result; stored
// words are not cleared.
// A stalled receiver holds the result in the output register; a new input is
// taken only when that register is empty or being emptied in the same cycle.
module stack_alu_ops
  import sao_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [7:0]  in_tuser,   // [2:0] func, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] top_value, [38:32] depth, rest zero
  output logic [7:0]  out_tuser   // [1:0] status, rest zero
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    SO_NONE = 2'd0,
    SO_PUSH = 2'd1,
    SO_POP  = 2'd2,
    SO_SWAP = 2'd3
  } stk_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [WORD_W-1:0]  out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  stk_op_t            op;
  logic [WORD_W-1:0]  pop_word;
  logic [WORD_W-1:0]  alu_res;
  logic [WORD_W-1:0]  cur_top;
  logic [WORD_W-1:0]  push_value;
  func_t              func;
  logic               in_fire;
  logic               full;
  logic               short;
  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_quot;
  logic [CW+DEPTH_W-1:0] cnt_ext;

  logic [WORD_W-1:0]  cell_q [STACK_DEPTH];
  logic [WORD_W-1:0]  above  [STACK_DEPTH];
  logic [WORD_W-1:0]  below  [STACK_DEPTH];
  cell_ctl_t          cell_ctl [STACK_DEPTH];

  assign func       = func_t'(in_tuser[FUNC_W-1:0]);
  assign push_value = in_tdata[WORD_W-1:0];
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign full       = (cnt_r == CW'(STACK_DEPTH));
  assign short      = (cnt_r < CW'(2));
  assign cur_top    = (cnt_r != '0) ? cell_q[0] : '0;
  assign alu_res    = (func == FN_ADD) ? (cell_q[1] + cell_q[0]) : (cell_q[1] - cell_q[0]);
  assign cnt_ext    = {{DEPTH_W{1'b0}}, cnt_nxt};

  // Sequencer: decode the operation, update the count and form the result.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op             = SO_NONE;
    pop_word       = alu_res;
    div_start      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_top_nxt    = cur_top;
      case (func)
        FN_PUSH: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            op          = SO_PUSH;
            cnt_nxt     = cnt_r + 1'b1;
            out_top_nxt = push_value;
          end
        end
        FN_SWAP, FN_ADD, FN_SUB, FN_DIV: begin
          if (short) begin
            out_status_nxt = ST_SHORT;
          end else if (func == FN_SWAP) begin
            op          = SO_SWAP;
            out_top_nxt = cell_q[1];
          end else if (func == FN_DIV) begin
            if (cell_q[0] == '0) begin
              out_status_nxt = ST_DIVZERO;
            end else begin
              div_start     = 1'b1;
              state_nxt     = S_DIV;
              out_valid_nxt = 1'b0;
            end
          end else begin
            op          = SO_POP;
            cnt_nxt     = cnt_r - 1'b1;
            out_top_nxt = alu_res;
          end
        end
        default: begin
          out_status_nxt = ST_OK;
        end
      endcase
    end else if (state_r == S_DIV && div_done) begin
      op             = SO_POP;
      pop_word       = div_quot;
      cnt_nxt        = cnt_r - 1'b1;
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_top_nxt    = div_quot;
    end
    out_depth_nxt = cnt_ext[DEPTH_W-1:0];
  end

  // Per-cell commands and neighbor links along the row.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      above[i] = (i == 0) ? push_value : cell_q[(i == 0) ? 0 : i - 1];
      below[i] = (i == STACK_DEPTH - 1) ? '0 : cell_q[(i == STACK_DEPTH - 1) ? i : i + 1];
      cell_ctl[i].load_word = (i == 0) ? ((op == SO_POP) ? pop_word : cell_q[1]) : cell_q[0];
      case (op)
        SO_PUSH: cell_ctl[i].cmd = CMD_SHIFT_DN;
        SO_POP:  cell_ctl[i].cmd = (i == 0) ? CMD_LOAD : CMD_SHIFT_UP;
        SO_SWAP: cell_ctl[i].cmd = (i < 2) ? CMD_LOAD : CMD_HOLD;
        default: cell_ctl[i].cmd = CMD_HOLD;
      endcase
    end
  end

  // Row of stack cells, top of stack in cell zero.
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    sao_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .above_word (above[g]),
      .below_word (below[g]),
      .word_q     (cell_q[g])
    );
  end

  // Iterative divider on the second word by the top word.
  sao_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cell_q[1]),
    .den   (cell_q[0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_top_r    <= (cnt_nxt != '0) ? out_top_nxt : '0;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_depth_r, out_top_r};
  assign out_tuser  = {6'b0, out_status_r};

  // The count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond capacity");

  // While dividing, no input is taken and no result is pending.
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> !in_tready && !out_valid_r)
    else $error("channel active during division");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside division");

  // An accepted push on a stack with room grows it by one.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && func == FN_PUSH && !full |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not grow the stack");

endmodule
